@@ hdl/vcore_placement_allocator_unit_assert.svh @@
// Assertion macros shared by the placement allocator RTL.
// Standalone header; a file that asserts includes it by name.
`ifndef VCORE_PLACEMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define VCORE_PLACEMENT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// The condition must never hold outside reset.
`define VPA_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("placement allocator check failed");
// The antecedent implies the consequent in the same cycle.
`define VPA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("placement allocator check failed");
`else
`define VPA_ASSERT_NEVER(lbl, clk, rstn, cond)
`define VPA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/vpa_pkg.sv @@
// Shared types and codes of the placement allocator.
// No dependencies.
package vpa_pkg;

    localparam int BW_WIDTH = 16;
    localparam int ID_WIDTH = 16;

    localparam logic [ID_WIDTH-1:0] FREE_OWNER = 16'hFFFF;

    localparam logic [1:0] ST_PLACED     = 2'd0;
    localparam logic [1:0] ST_NOT_PLACED = 2'd1;
    localparam logic [1:0] ST_RELEASED   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG   = 2'd3;

    localparam logic REG_SEARCH_MODE = 1'b0;
    localparam logic REG_NODE_CAP    = 1'b1;

    localparam logic REQ_DEMAND  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic MODE_FIRST_FIT = 1'b0;

    // Control from the sequencer to the node table.
    typedef struct packed {
        logic we;      // write bandwidth and busy count at waddr
        logic clr_bw;  // reload every node's bandwidth from capacity
    } node_ctl_t;

endpackage

@@ hdl/vpa_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/vpa_node_tbl.sv @@
// Per-node free bandwidth and busy count, two RAMs with valid bits.
// Depends on vpa_pkg and vpa_ram.
module vpa_node_tbl #(
    parameter int NODES = 64,
    parameter int BUSY_W = 5,
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                       clk,
    input  logic                       rstn,
    input  vpa_pkg::node_ctl_t         ctl,
    input  logic [NW-1:0]              raddr,
    input  logic [NW-1:0]              waddr,
    input  logic [vpa_pkg::BW_WIDTH-1:0] bw_wdata,
    input  logic [BUSY_W-1:0]          busy_wdata,
    input  logic [vpa_pkg::BW_WIDTH-1:0] cap,
    output logic [vpa_pkg::BW_WIDTH-1:0] bw_rdata,
    output logic [BUSY_W-1:0]          busy_rdata
);

    // An entry not yet written reads as capacity (bandwidth) or zero (busy).
    logic [NODES-1:0] bw_vld_reg;
    logic [NODES-1:0] busy_vld_reg;
    logic             bw_hit_reg;
    logic             busy_hit_reg;
    logic [vpa_pkg::BW_WIDTH-1:0] bw_ram;
    logic [BUSY_W-1:0]          busy_ram;

    vpa_ram #(.WIDTH(vpa_pkg::BW_WIDTH), .DEPTH(NODES)) u_bw_ram (
        .clk(clk), .we(ctl.we), .waddr(waddr), .wdata(bw_wdata),
        .raddr(raddr), .rdata(bw_ram)
    );

    vpa_ram #(.WIDTH(BUSY_W), .DEPTH(NODES)) u_busy_ram (
        .clk(clk), .we(ctl.we), .waddr(waddr), .wdata(busy_wdata),
        .raddr(raddr), .rdata(busy_ram)
    );

    always_ff @(posedge clk) begin
        if (!rstn) begin
            bw_vld_reg   <= '0;
            busy_vld_reg <= '0;
            bw_hit_reg   <= 1'b0;
            busy_hit_reg <= 1'b0;
        end else begin
            bw_hit_reg   <= bw_vld_reg[raddr];
            busy_hit_reg <= busy_vld_reg[raddr];
            if (ctl.clr_bw) begin
                bw_vld_reg <= '0;
            end else if (ctl.we) begin
                bw_vld_reg[waddr] <= 1'b1;
            end
            if (ctl.we) begin
                busy_vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign bw_rdata   = bw_hit_reg ? bw_ram : cap;
    assign busy_rdata = busy_hit_reg ? busy_ram : '0;

endmodule

@@ hdl/vcore_placement_allocator_unit.sv @@
// Top level of the core placement allocator: sequencer, owner RAM, demand buffer.
// Depends on vpa_pkg, vpa_ram, vpa_node_tbl and the assertion header.
//
//  Channel   Direction  Handshake              Carries
//  s_*       in         s_valid / s_ready      demand or release transaction
//  m_*       out        m_valid / m_ready      placed, not placed, released, too long
//  cfg_*     in         cfg_wr_en              search mode, node capacity
//
// A demand transaction that is not the last of a request is stored in S_IDLE.
// A release passes S_REL_DIV, S_REL_REM, S_REL_RD, S_REL_WR, S_EMIT_LD and S_EMIT,
// where it waits for the result to be taken. The search visits one core per cycle
// through the owner RAM read port, with a pass through S_NODE for each node; each
// chosen core then takes S_CM_RD and S_CM_WR for the node table read-modify-write,
// and each emitted result takes S_EMIT_LD and S_EMIT. After reset the owner RAM
// is cleared one core per cycle, during which s_ready stays low.
// The block works on one transaction at a time; a stalled result holds everything.
`include "vcore_placement_allocator_unit_assert.svh"

module vcore_placement_allocator_unit #(
    parameter int NODES = 64,
    parameter int CORES_PER_NODE = 16,
    parameter int MAX_REQ = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_bandwidth,
    input  logic [15:0] s_vm_id,
    input  logic [9:0]  s_core_index,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_core_index_out,
    output logic [6:0]  m_servers_on,
    output logic [10:0] m_free_cores,
    output logic        m_last_out
);

    localparam int TOTAL = NODES * CORES_PER_NODE;
    localparam int GW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(CORES_PER_NODE + 1);
    localparam int CW = $clog2(MAX_REQ + 1);
    localparam int PW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
    localparam int FW = $clog2(TOTAL + 1);
    localparam int VW = $clog2(NODES + 1);
    localparam int SHIFT = 20;
    localparam int RECIP = (1 << SHIFT) / CORES_PER_NODE;
    localparam int BWW = vpa_pkg::BW_WIDTH;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REL_DIV, S_REL_REM, S_REL_RD, S_REL_WR,
        S_NODE, S_SCAN, S_CM_RD, S_CM_WR, S_EMIT_LD, S_EMIT
    } state_t;

    state_t state_reg;

    logic           mode_reg;
    logic [BWW-1:0] cap_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  ptr_reg;
    logic [BWW-1:0] dem_reg [MAX_REQ];
    logic [NW-1:0]  pick_node_reg [MAX_REQ];
    logic [SW-1:0]  pick_slot_reg [MAX_REQ];
    logic [NW-1:0]  rr_node_reg;
    logic [SW-1:0]  rr_core_reg;
    logic [VW-1:0]  srv_reg;
    logic [FW-1:0]  free_reg;
    logic [NW-1:0]  node_reg;
    logic [SW-1:0]  slot_reg;
    logic [NW-1:0]  visit_reg;
    logic           first_reg;
    logic [BWW-1:0] budget_reg;
    logic [GW:0]    clr_addr_reg;
    logic [9:0]     rel_idx_reg;
    logic [BWW-1:0] rel_bw_reg;
    logic [9:0]     quot_reg;
    logic [NW-1:0]  rel_node_reg;
    logic [1:0]     out_status_reg;
    logic [9:0]     out_index_reg;
    logic [6:0]     out_srv_reg;
    logic [10:0]    out_free_reg;
    logic           out_last_reg;

    // Owner RAM holds one bit per core: set when the core is taken.
    logic          own_we;
    logic [GW-1:0] own_waddr;
    logic          own_wdata;
    logic [GW-1:0] own_raddr;
    logic          own_rdata;

    vpa_pkg::node_ctl_t node_ctl;
    logic [NW-1:0]  nt_raddr;
    logic [NW-1:0]  nt_waddr;
    logic [BWW-1:0] nt_bw_wdata;
    logic [SW-1:0]  nt_busy_wdata;
    logic [BWW-1:0] nt_bw_rdata;
    logic [SW-1:0]  nt_busy_rdata;

    vpa_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_owner_ram (
        .clk(aclk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata)
    );

    vpa_node_tbl #(.NODES(NODES), .BUSY_W(SW)) u_node_tbl (
        .clk(aclk), .rstn(aresetn), .ctl(node_ctl),
        .raddr(nt_raddr), .waddr(nt_waddr),
        .bw_wdata(nt_bw_wdata), .busy_wdata(nt_busy_wdata),
        .cap(cap_reg), .bw_rdata(nt_bw_rdata), .busy_rdata(nt_busy_rdata)
    );

    // Core address of the slot under scan, and of the pick at ptr_reg.
    logic [GW:0]    g_cur;
    logic [GW:0]    g_next;
    logic [GW:0]    g_pick;
    logic [GW+9:0]  g_pick_ext;
    logic [GW+9:0]  rel_idx_ext;
    logic [PW-1:0]  p_idx;
    logic [BWW-1:0] budget_eff;
    logic [BWW-1:0] dem_cur;
    logic           take;
    logic           req_done;
    logic           last_visit;
    logic [NW-1:0]  node_inc;
    logic           in_range;
    logic           rel_hit;
    logic [BWW:0]   bw_sum;
    logic [30:0]    quot_prod;
    logic [19:0]    rel_rem;
    logic [9:0]     quot_fix;
    logic [VW+6:0]  srv_ext;
    logic [FW+10:0] free_ext;

    assign p_idx       = ptr_reg[PW-1:0];
    assign g_cur       = (GW+1)'(node_reg) * (GW+1)'(CORES_PER_NODE) + (GW+1)'(slot_reg);
    assign g_next      = g_cur + (GW+1)'(1);
    assign g_pick      = (GW+1)'(pick_node_reg[p_idx]) * (GW+1)'(CORES_PER_NODE)
                       + (GW+1)'(pick_slot_reg[p_idx]);
    assign g_pick_ext  = (GW+10)'(g_pick);
    assign rel_idx_ext = (GW+10)'(rel_idx_reg);
    assign dem_cur     = dem_reg[p_idx];
    assign budget_eff  = first_reg ? nt_bw_rdata : budget_reg;
    assign take        = !own_rdata && (budget_eff >= dem_cur);
    assign req_done    = (ptr_reg + CW'(1)) == cnt_reg;
    assign last_visit  = visit_reg == NW'(NODES - 1);
    assign node_inc    = (node_reg == NW'(NODES - 1)) ? '0 : node_reg + NW'(1);
    assign in_range    = 32'(rel_idx_reg) < 32'(TOTAL);
    assign rel_hit     = in_range && own_rdata;
    assign bw_sum      = (BWW+1)'(nt_bw_rdata) + (BWW+1)'(rel_bw_reg);
    assign quot_prod   = 31'(rel_idx_reg) * 31'(RECIP);
    assign rel_rem     = 20'(rel_idx_reg) - 20'(quot_reg) * 20'(CORES_PER_NODE);
    assign quot_fix    = (rel_rem >= 20'(CORES_PER_NODE)) ? quot_reg + 10'd1 : quot_reg;
    assign srv_ext     = (VW+7)'(srv_reg);
    assign free_ext    = (FW+11)'(free_reg);

    always_comb begin
        own_we    = 1'b0;
        own_waddr = clr_addr_reg[GW-1:0];
        own_wdata = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                own_we = 1'b1;
            end
            S_CM_WR: begin
                own_we    = 1'b1;
                own_waddr = g_pick[GW-1:0];
                own_wdata = 1'b1;
            end
            S_REL_WR: begin
                own_we    = rel_hit;
                own_waddr = rel_idx_ext[GW-1:0];
            end
            default: begin
                own_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            S_SCAN:   own_raddr = g_next[GW-1:0];
            S_REL_RD: own_raddr = rel_idx_ext[GW-1:0];
            default:  own_raddr = g_cur[GW-1:0];
        endcase
    end

    always_comb begin
        node_ctl.clr_bw = cfg_wr_en && (cfg_index == vpa_pkg::REG_NODE_CAP);
        node_ctl.we     = (state_reg == S_CM_WR) || ((state_reg == S_REL_WR) && rel_hit);
        case (state_reg)
            S_CM_RD:  nt_raddr = pick_node_reg[p_idx];
            S_REL_RD: nt_raddr = rel_node_reg;
            default:  nt_raddr = node_reg;
        endcase
        if (state_reg == S_CM_WR) begin
            nt_waddr      = pick_node_reg[p_idx];
            nt_bw_wdata   = nt_bw_rdata - dem_cur;
            nt_busy_wdata = nt_busy_rdata + SW'(1);
        end else begin
            nt_waddr      = rel_node_reg;
            nt_bw_wdata   = bw_sum[BWW] ? {BWW{1'b1}} : bw_sum[BWW-1:0];
            nt_busy_wdata = (nt_busy_rdata != '0) ? nt_busy_rdata - SW'(1) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            mode_reg     <= vpa_pkg::MODE_FIRST_FIT;
            cap_reg      <= 16'd1000;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            rr_node_reg  <= '0;
            rr_core_reg  <= '0;
            srv_reg      <= '0;
            free_reg     <= FW'(TOTAL);
            clr_addr_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == vpa_pkg::REG_SEARCH_MODE) begin
                    mode_reg <= cfg_wdata[0];
                end else begin
                    cap_reg <= cfg_wdata;
                end
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + (GW+1)'(1);
                    if (clr_addr_reg == (GW+1)'(TOTAL - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        out_last_reg <= 1'b1;
                        out_index_reg <= '0;
                        out_srv_reg <= srv_ext[6:0];
                        out_free_reg <= free_ext[10:0];
                        if (s_req_type == vpa_pkg::REQ_RELEASE) begin
                            rel_idx_reg <= s_core_index;
                            rel_bw_reg  <= s_bandwidth;
                            state_reg   <= S_REL_DIV;
                        end else if (cnt_reg == CW'(MAX_REQ)) begin
                            cnt_reg        <= '0;
                            out_status_reg <= vpa_pkg::ST_TOO_LONG;
                            state_reg      <= S_EMIT;
                        end else begin
                            dem_reg[cnt_reg[PW-1:0]] <= s_bandwidth;
                            cnt_reg <= cnt_reg + CW'(1);
                            if (s_last) begin
                                if (s_vm_id == vpa_pkg::FREE_OWNER) begin
                                    cnt_reg        <= '0;
                                    out_status_reg <= vpa_pkg::ST_NOT_PLACED;
                                    state_reg      <= S_EMIT;
                                end else begin
                                    ptr_reg   <= '0;
                                    visit_reg <= '0;
                                    if (mode_reg == vpa_pkg::MODE_FIRST_FIT) begin
                                        node_reg <= '0;
                                        slot_reg <= '0;
                                    end else begin
                                        node_reg    <= rr_node_reg;
                                        slot_reg    <= rr_core_reg;
                                        rr_core_reg <= '0;
                                    end
                                    state_reg <= S_NODE;
                                end
                            end
                        end
                    end
                end
                S_REL_DIV: begin
                    quot_reg  <= quot_prod[SHIFT+9:SHIFT];
                    state_reg <= S_REL_REM;
                end
                S_REL_REM: begin
                    rel_node_reg <= quot_fix[NW-1:0];
                    state_reg    <= S_REL_RD;
                end
                S_REL_RD: begin
                    state_reg <= S_REL_WR;
                end
                S_REL_WR: begin
                    if (rel_hit) begin
                        free_reg <= free_reg + FW'(1);
                        if ((nt_busy_rdata == SW'(1)) && (srv_reg != '0)) begin
                            srv_reg <= srv_reg - VW'(1);
                        end
                    end
                    out_status_reg <= vpa_pkg::ST_RELEASED;
                    out_index_reg  <= rel_idx_reg;
                    state_reg      <= S_EMIT_LD;
                end
                S_NODE: begin
                    first_reg <= 1'b1;
                    if (slot_reg >= SW'(CORES_PER_NODE)) begin
                        if (last_visit) begin
                            cnt_reg        <= '0;
                            out_status_reg <= vpa_pkg::ST_NOT_PLACED;
                            out_index_reg  <= '0;
                            state_reg      <= S_EMIT_LD;
                        end else begin
                            visit_reg <= visit_reg + NW'(1);
                            node_reg  <= node_inc;
                            slot_reg  <= '0;
                        end
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    first_reg  <= 1'b0;
                    budget_reg <= budget_eff;
                    if (take) begin
                        pick_node_reg[p_idx] <= node_reg;
                        pick_slot_reg[p_idx] <= slot_reg;
                        budget_reg <= budget_eff - dem_cur;
                        ptr_reg    <= ptr_reg + CW'(1);
                    end
                    if (take && req_done) begin
                        if (mode_reg != vpa_pkg::MODE_FIRST_FIT) begin
                            rr_node_reg <= node_reg;
                            rr_core_reg <= slot_reg + SW'(1);
                        end
                        ptr_reg   <= '0;
                        state_reg <= S_CM_RD;
                    end else if (slot_reg + SW'(1) < SW'(CORES_PER_NODE)) begin
                        slot_reg <= slot_reg + SW'(1);
                    end else begin
                        slot_reg  <= SW'(CORES_PER_NODE);
                        state_reg <= S_NODE;
                    end
                end
                S_CM_RD: begin
                    state_reg <= S_CM_WR;
                end
                S_CM_WR: begin
                    if (nt_busy_rdata == '0) begin
                        srv_reg <= srv_reg + VW'(1);
                    end
                    if (req_done) begin
                        free_reg       <= free_reg - FW'(cnt_reg);
                        ptr_reg        <= '0;
                        out_status_reg <= vpa_pkg::ST_PLACED;
                        state_reg      <= S_EMIT_LD;
                    end else begin
                        ptr_reg   <= ptr_reg + CW'(1);
                        state_reg <= S_CM_RD;
                    end
                end
                S_EMIT_LD: begin
                    // Counts are final here; placed results also take their core index.
                    out_srv_reg  <= srv_ext[6:0];
                    out_free_reg <= free_ext[10:0];
                    if (out_status_reg == vpa_pkg::ST_PLACED) begin
                        out_index_reg  <= g_pick_ext[9:0];
                        out_last_reg   <= req_done;
                    end else begin
                        out_last_reg <= 1'b1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_ready) begin
                        if (out_status_reg == vpa_pkg::ST_PLACED && !req_done) begin
                            ptr_reg   <= ptr_reg + CW'(1);
                            state_reg <= S_EMIT_LD;
                        end else begin
                            // A release leaves a partly loaded request in place.
                            if (out_status_reg != vpa_pkg::ST_RELEASED) begin
                                cnt_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_EMIT);
    assign m_status         = out_status_reg;
    assign m_core_index_out = out_index_reg;
    assign m_servers_on     = out_srv_reg;
    assign m_free_cores     = out_free_reg;
    assign m_last_out       = out_last_reg;

    // A result and a new transaction are never offered together.
    `VPA_ASSERT_NEVER(a_one_at_a_time, aclk, aresetn, s_ready && m_valid)
    // The owner RAM sweep keeps the input closed.
    `VPA_ASSERT_IMPLY(a_clear_blocks, aclk, aresetn, state_reg == S_CLEAR, !s_ready)
    // Free cores never exceed the table size.
    `VPA_ASSERT_NEVER(a_free_bound, aclk, aresetn, free_reg > FW'(TOTAL))
    // Active nodes never exceed the node count.
    `VPA_ASSERT_NEVER(a_srv_bound, aclk, aresetn, srv_reg > VW'(NODES))

endmodule
